// ===== design/dhd_pkg.sv =====
// ============================================================================
// dhd_pkg: shared types and constants for the detection head decoder
// Item types, fixed-point constants, register indexes and the command and
// status types that join the controller and the datapath.
// ============================================================================
`default_nettype none

package dhd_pkg;

    localparam int MAX_BOXES_DEF   = 4;
    localparam int CLASSES_MAX_DEF = 64;
    localparam int NUM_GEOM        = 5;
    localparam int DIV_STEPS       = 17;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] EXP2_C1   = 16'd44014;
    localparam logic [13:0] EXP2_C2   = 14'd11246;
    localparam logic [21:0] E4_Q16    = 22'd3578144;
    localparam logic [31:0] ONE_Q16   = 32'd65536;
    localparam logic signed [16:0] CLAMP_Q88 = 17'sd1024;

    localparam logic [2:0] CFG_BOXES   = 3'd0;
    localparam logic [2:0] CFG_CLASSES = 3'd1;
    localparam logic [2:0] CFG_MODE    = 3'd2;
    localparam logic [2:0] CFG_ANCH_LO = 3'd3;
    localparam logic [2:0] CFG_ANCH_HI = 3'd4;

    typedef struct packed {
        logic signed [15:0] logit;
        logic               cell_start;
    } t_in;

    typedef struct packed {
        logic [31:0] activated;
        logic [1:0]  box_index;
        logic [6:0]  channel_index;
        logic        run_last;
    } t_out;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_NE_ITEM,
        OP_NE_BUF,
        OP_DIV_SIG,
        OP_DIV_SMX,
        OP_GX1,
        OP_GX2,
        OP_GX3,
        OP_GX4,
        OP_BUF_RD,
        OP_BUF_WB,
        OP_EMIT_ITEM,
        OP_EMIT_SMX
    } t_op;

    typedef enum logic [1:0] {
        K_SIG,
        K_GEXP,
        K_SMX_WAIT,
        K_SMX_LAST
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  ne_done;
        logic  div_done;
        logic  idx_last;
        logic  out_busy;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/dhd_ctrl.sv =====
// ============================================================================
// dhd_ctrl: sequencing controller
// Steps the datapath through activation, divide and softmax passes.
// ============================================================================
`default_nettype none

module dhd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output dhd_pkg::t_op       o_op,
    input  wire dhd_pkg::t_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_NE,
        S_DIV,
        S_GX2,
        S_GX3,
        S_GX4,
        S_EMIT,
        S_P1_RD,
        S_P1_NE,
        S_P1_WAIT,
        S_P2_RD,
        S_P2_DIV,
        S_P2_WAIT,
        S_P2_EMIT
    } t_state;

    t_state r_state, n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_op    = dhd_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = dhd_pkg::OP_ACCEPT;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.kind)
                    dhd_pkg::K_SMX_WAIT: n_state = S_IDLE;
                    dhd_pkg::K_SMX_LAST: n_state = S_P1_RD;
                    default: begin
                        o_op    = dhd_pkg::OP_NE_ITEM;
                        n_state = S_NE;
                    end
                endcase
            end
            S_NE: begin
                if (i_stat.ne_done) begin
                    if (i_stat.kind == dhd_pkg::K_GEXP) begin
                        o_op    = dhd_pkg::OP_GX1;
                        n_state = S_GX2;
                    end else begin
                        o_op    = dhd_pkg::OP_DIV_SIG;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_GX2: begin
                o_op    = dhd_pkg::OP_GX2;
                n_state = S_GX3;
            end
            S_GX3: begin
                o_op    = dhd_pkg::OP_GX3;
                n_state = S_GX4;
            end
            S_GX4: begin
                o_op    = dhd_pkg::OP_GX4;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_op    = dhd_pkg::OP_EMIT_ITEM;
                    n_state = S_IDLE;
                end
            end
            S_P1_RD: begin
                o_op    = dhd_pkg::OP_BUF_RD;
                n_state = S_P1_NE;
            end
            S_P1_NE: begin
                o_op    = dhd_pkg::OP_NE_BUF;
                n_state = S_P1_WAIT;
            end
            S_P1_WAIT: begin
                if (i_stat.ne_done) begin
                    o_op    = dhd_pkg::OP_BUF_WB;
                    n_state = i_stat.idx_last ? S_P2_RD : S_P1_RD;
                end
            end
            S_P2_RD: begin
                o_op    = dhd_pkg::OP_BUF_RD;
                n_state = S_P2_DIV;
            end
            S_P2_DIV: begin
                o_op    = dhd_pkg::OP_DIV_SMX;
                n_state = S_P2_WAIT;
            end
            S_P2_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_P2_EMIT;
                end
            end
            S_P2_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_op    = dhd_pkg::OP_EMIT_SMX;
                    n_state = i_stat.idx_last ? S_IDLE : S_P2_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/dhd_dpath.sv =====
// ============================================================================
// dhd_dpath: decoder datapath
// Configuration, counters, exp pipeline, restoring divider, class buffer
// and the output register.
// ============================================================================
`default_nettype none

module dhd_dpath #(
    parameter int MAX_BOXES   = dhd_pkg::MAX_BOXES_DEF,
    parameter int CLASSES_MAX = dhd_pkg::CLASSES_MAX_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dhd_pkg::t_in    i_data,
    input  wire logic            i_cfg_valid,
    input  wire logic [2:0]      i_cfg_index,
    input  wire logic [63:0]     i_cfg_data,
    input  wire dhd_pkg::t_op    i_op,
    output dhd_pkg::t_stat       o_stat,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output dhd_pkg::t_out        o_data
);

    localparam int CW = (CLASSES_MAX > 1) ? $clog2(CLASSES_MAX) : 1;
    localparam logic [6:0] NC_MAX = 7'(CLASSES_MAX);
    localparam logic [6:0] K_MAX  = 7'(CLASSES_MAX - 1);
    localparam logic [2:0] NB_MAX = 3'(MAX_BOXES);
    localparam logic [6:0] GEOM7  = 7'(dhd_pkg::NUM_GEOM);

    // Configuration registers.
    logic [2:0]  r_boxes;
    logic [6:0]  r_classes;
    logic        r_mode;
    logic [63:0] r_anch_lo, r_anch_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boxes   <= 3'd3;
            r_classes <= 7'd20;
            r_mode    <= 1'b0;
            r_anch_lo <= '0;
            r_anch_hi <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                dhd_pkg::CFG_BOXES:   r_boxes   <= i_cfg_data[2:0];
                dhd_pkg::CFG_CLASSES: r_classes <= i_cfg_data[6:0];
                dhd_pkg::CFG_MODE:    r_mode    <= i_cfg_data[0];
                dhd_pkg::CFG_ANCH_LO: r_anch_lo <= i_cfg_data;
                dhd_pkg::CFG_ANCH_HI: r_anch_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [2:0] nb;
    logic [6:0] nc;
    assign nb = (r_boxes == 3'd0) ? 3'd1 : ((r_boxes > NB_MAX) ? NB_MAX : r_boxes);
    assign nc = (r_classes == 7'd0) ? 7'd1 : ((r_classes > NC_MAX) ? NC_MAX : r_classes);

    // Position counters and the item being worked on.
    logic [6:0]         r_ch, r_ich;
    logic [1:0]         r_box, r_ibox;
    logic signed [15:0] r_x, r_max;
    dhd_pkg::t_kind     r_kind;
    logic [CW-1:0]      r_klast, r_idx;
    logic [22:0]        r_sum;

    logic [6:0]     ch_now, k_raw, k_cl;
    logic [1:0]     box_now;
    logic [7:0]     ch_inc;
    logic [2:0]     box_inc;
    logic           ch_wrap, box_wrap, is_class, is_smx, smx_last;
    logic [CW-1:0]  k_idx;
    dhd_pkg::t_kind kind_now;

    always_comb begin
        ch_now   = i_data.cell_start ? 7'd0 : r_ch;
        box_now  = i_data.cell_start ? 2'd0 : r_box;
        ch_inc   = {1'b0, ch_now} + 8'd1;
        ch_wrap  = ch_inc >= ({1'b0, GEOM7} + {1'b0, nc});
        box_inc  = {1'b0, box_now} + 3'd1;
        box_wrap = box_inc >= nb;
        is_class = ch_now >= GEOM7;
        is_smx   = is_class && !r_mode;
        k_raw    = ch_now - GEOM7;
        k_cl     = (k_raw > K_MAX) ? K_MAX : k_raw;
        k_idx    = k_cl[CW-1:0];
        smx_last = ({1'b0, k_cl} + 8'd1) >= {1'b0, nc};
        if (!is_class) begin
            kind_now = (ch_now == 7'd2 || ch_now == 7'd3) ? dhd_pkg::K_GEXP : dhd_pkg::K_SIG;
        end else if (r_mode) begin
            kind_now = dhd_pkg::K_SIG;
        end else begin
            kind_now = smx_last ? dhd_pkg::K_SMX_LAST : dhd_pkg::K_SMX_WAIT;
        end
    end

    // Class buffer: raw logits on accept, then the exp terms of pass one.
    logic [16:0] r_mem [CLASSES_MAX];
    logic [16:0] r_rd;
    logic        mem_we;
    logic [CW-1:0] mem_wa;
    logic [16:0] mem_wd;
    logic [30:0] r_ne;

    assign mem_we = (i_op == dhd_pkg::OP_ACCEPT && is_smx) || (i_op == dhd_pkg::OP_BUF_WB);
    assign mem_wa = (i_op == dhd_pkg::OP_ACCEPT) ? k_idx : r_idx;
    assign mem_wd = (i_op == dhd_pkg::OP_ACCEPT) ? {i_data.logit[15], i_data.logit}
                                                 : r_ne[30:14];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_op == dhd_pkg::OP_BUF_RD) begin
            r_rd <= r_mem[r_idx];
        end
    end

    logic idx_last;
    assign idx_last = (r_idx == r_klast);

    always_ff @(posedge i_clk) begin
        if (i_op == dhd_pkg::OP_ACCEPT) begin
            r_x    <= i_data.logit;
            r_ich  <= ch_now;
            r_ibox <= box_now;
            r_kind <= kind_now;
            r_klast <= k_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch  <= '0;
            r_box <= '0;
            r_max <= 16'sh8000;
            r_sum <= '0;
            r_idx <= '0;
        end else begin
            unique case (i_op)
                dhd_pkg::OP_ACCEPT: begin
                    r_ch <= ch_wrap ? 7'd0 : ch_inc[6:0];
                    if (ch_wrap) begin
                        r_box <= box_wrap ? 2'd0 : box_inc[1:0];
                    end else begin
                        r_box <= box_now;
                    end
                    if (is_smx && (k_cl == 7'd0 || i_data.logit > r_max)) begin
                        r_max <= i_data.logit;
                    end
                    if (is_smx && smx_last) begin
                        r_sum <= '0;
                        r_idx <= '0;
                    end
                end
                dhd_pkg::OP_BUF_WB: begin
                    r_sum <= r_sum + {6'd0, r_ne[30:14]};
                    r_idx <= idx_last ? '0 : r_idx + 1'b1;
                end
                dhd_pkg::OP_EMIT_SMX: begin
                    r_idx <= idx_last ? '0 : r_idx + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Exponent argument: |x| for a sigmoid, 4 - clamp(x) for box size,
    // max - logit for the softmax pass (a stale larger entry gives zero).
    logic signed [16:0] x17, v17;
    logic [16:0] x_abs, a_geo, a_buf, ne_a;
    logic signed [17:0] diff;
    logic ne_start;

    always_comb begin
        x17   = $signed({r_x[15], r_x});
        x_abs = r_x[15] ? (17'd0 - {r_x[15], r_x}) : {1'b0, r_x};
        if (x17 < -dhd_pkg::CLAMP_Q88) begin
            v17 = -dhd_pkg::CLAMP_Q88;
        end else if (x17 > dhd_pkg::CLAMP_Q88) begin
            v17 = dhd_pkg::CLAMP_Q88;
        end else begin
            v17 = x17;
        end
        a_geo = dhd_pkg::CLAMP_Q88 - v17;
        diff  = $signed({r_max[15], r_max[15], r_max}) - $signed({r_rd[16], r_rd});
        a_buf = diff[17] ? 17'd0 : diff[16:0];
        if (i_op == dhd_pkg::OP_NE_BUF) begin
            ne_a = a_buf;
        end else begin
            ne_a = (r_kind == dhd_pkg::K_GEXP) ? a_geo : x_abs;
        end
        ne_start = (i_op == dhd_pkg::OP_NE_ITEM) || (i_op == dhd_pkg::OP_NE_BUF);
    end

    // exp(-a) pipeline, four stages, result in Q1.30.
    logic        r_v1, r_v2, r_v3, r_v4;
    logic [33:0] r_y;
    logic [31:0] r_p1, r_pff;
    logic [9:0]  r_n2, r_n3;
    logic [15:0] r_t1;
    logic [29:0] r_p2;
    logic [16:0] mant;
    logic [30:0] mant_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= ne_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_comb begin
        mant    = 17'd65536 - {1'b0, r_t1} + {3'd0, r_p2[29:16]};
        mant_sh = {mant, 14'd0};
    end

    always_ff @(posedge i_clk) begin
        if (ne_start) begin
            r_y <= {17'd0, ne_a} * {17'd0, dhd_pkg::LOG2E_Q16};
        end
        if (r_v1) begin
            r_p1  <= {16'd0, r_y[23:8]} * {16'd0, dhd_pkg::EXP2_C1};
            r_pff <= {16'd0, r_y[23:8]} * {16'd0, r_y[23:8]};
            r_n2  <= r_y[33:24];
        end
        if (r_v2) begin
            r_t1 <= r_p1[31:16];
            r_p2 <= {14'd0, r_pff[31:16]} * {16'd0, dhd_pkg::EXP2_C2};
            r_n3 <= r_n2;
        end
        if (r_v3) begin
            r_ne <= (r_n3 >= 10'd31) ? 31'd0 : (mant_sh >> r_n3[4:0]);
        end
    end

    // Restoring divider, one quotient bit per cycle.
    logic [32:0] r_drem;
    logic [31:0] r_dden;
    logic [16:0] r_dlow, r_dq;
    logic [4:0]  r_dcnt;
    logic        r_dbusy, r_ddone;
    logic [31:0] d_sig;
    logic [46:0] num;
    logic [31:0] den;
    logic [32:0] trial;
    logic        qbit, div_start;

    always_comb begin
        d_sig = 32'h4000_0000 + {1'b0, r_ne};
        if (i_op == dhd_pkg::OP_DIV_SIG) begin
            num = {1'b1, 46'd0} + {16'd0, d_sig[31:1]};
            den = d_sig;
        end else begin
            num = {14'd0, r_rd, 16'd0} + {25'd0, r_sum[22:1]};
            den = {9'd0, r_sum};
        end
        div_start = (i_op == dhd_pkg::OP_DIV_SIG) || (i_op == dhd_pkg::OP_DIV_SMX);
        trial = {r_drem[31:0], r_dlow[16]};
        qbit  = trial >= {1'b0, r_dden};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
        end else begin
            r_ddone <= 1'b0;
            if (div_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && r_dcnt == 5'd1) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_drem <= {3'd0, num[46:17]};
            r_dlow <= num[16:0];
            r_dden <= den;
            r_dcnt <= 5'(dhd_pkg::DIV_STEPS);
        end else if (r_dbusy) begin
            r_drem <= qbit ? (trial - {1'b0, r_dden}) : trial;
            r_dlow <= {r_dlow[15:0], 1'b0};
            r_dq   <= {r_dq[15:0], qbit};
            r_dcnt <= r_dcnt - 5'd1;
        end
    end

    // Box size: exp term times e^4, then times the anchor. The product
    // tops out near 2^30, so it always fits the 32-bit result.
    logic [37:0] r_plo;
    logic [36:0] r_phi;
    logic [21:0] r_ge;
    logic [31:0] r_res;
    logic [52:0] gsum;
    logic [31:0] anch_pair;
    logic [15:0] anch;
    logic [37:0] gprod;

    always_comb begin
        gsum      = {r_phi, 16'd0} + {15'd0, r_plo};
        anch_pair = r_ibox[1] ? (r_ibox[0] ? r_anch_hi[63:32] : r_anch_hi[31:0])
                              : (r_ibox[0] ? r_anch_lo[63:32] : r_anch_lo[31:0]);
        anch      = r_ich[0] ? anch_pair[31:16] : anch_pair[15:0];
        gprod     = {16'd0, r_ge} * {22'd0, anch};
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            dhd_pkg::OP_GX1: r_plo <= {22'd0, r_ne[15:0]} * {16'd0, dhd_pkg::E4_Q16};
            dhd_pkg::OP_GX2: r_phi <= {22'd0, r_ne[30:16]} * {15'd0, dhd_pkg::E4_Q16};
            dhd_pkg::OP_GX3: r_ge  <= gsum[51:30];
            dhd_pkg::OP_GX4: r_res <= {2'd0, gprod[37:8]};
            default: ;
        endcase
    end

    // Output register.
    logic          r_ov;
    dhd_pkg::t_out r_od;
    logic [31:0]   sig_val;

    assign sig_val = r_x[15] ? (dhd_pkg::ONE_Q16 - {15'd0, r_dq}) : {15'd0, r_dq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_op == dhd_pkg::OP_EMIT_ITEM || i_op == dhd_pkg::OP_EMIT_SMX) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == dhd_pkg::OP_EMIT_ITEM) begin
            r_od.activated     <= (r_kind == dhd_pkg::K_GEXP) ? r_res : sig_val;
            r_od.box_index     <= r_ibox;
            r_od.channel_index <= r_ich;
            r_od.run_last      <= 1'b1;
        end else if (i_op == dhd_pkg::OP_EMIT_SMX) begin
            r_od.activated     <= (r_sum == 23'd0) ? 32'd0 : {15'd0, r_dq};
            r_od.box_index     <= r_ibox;
            r_od.channel_index <= GEOM7 + 7'(r_idx);
            r_od.run_last      <= idx_last;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

    always_comb begin
        o_stat.kind     = r_kind;
        o_stat.ne_done  = r_v4;
        o_stat.div_done = r_ddone;
        o_stat.idx_last = idx_last;
        o_stat.out_busy = r_ov && !i_ready;
    end

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == dhd_pkg::OP_EMIT_ITEM || i_op == dhd_pkg::OP_EMIT_SMX)
            |-> !(r_ov && !i_ready))
        else $error("result loaded over one still waiting");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !r_dbusy)
        else $error("divider restarted while busy");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == dhd_pkg::OP_EMIT_SMX) |-> (r_idx <= r_klast))
        else $error("softmax emit past the last class");
`endif

endmodule

`default_nettype wire

// ===== design/detection_head_decode.sv =====
// ============================================================================
// detection_head_decode: region layer decoder for a detection head
// Activates a stream of Q8.8 logits into Q16.16 box geometry and class scores.
// ============================================================================
// One logit is taken per input item. A box-size channel (2 or 3) passes through
// the four-stage exp pipeline, then three multiply steps. A sigmoid channel
// passes through the exp pipeline and then the shared restoring divider, which
// produces its 17-bit quotient one bit per cycle. In softmax mode a class that
// is not the last is only buffered and gives no result. The last class of a
// box starts two passes over the buffered classes: an exp pass through the exp
// pipeline, then a normalize pass through the divider, each taking one class
// at a time; no new item is accepted until both end. Results wait in an output
// register; a stalled output holds the sequencer only when a new result is
// ready to be loaded. The class buffer needs no clearing after reset.
// Configuration writes are taken at any time but must be made while the block
// is idle.
`default_nettype none

module detection_head_decode #(
    parameter int MAX_BOXES   = dhd_pkg::MAX_BOXES_DEF,
    parameter int CLASSES_MAX = dhd_pkg::CLASSES_MAX_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire dhd_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output dhd_pkg::t_out      o_data,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [63:0]   i_cfg_data
);

    dhd_pkg::t_op   op;
    dhd_pkg::t_stat stat;

    // Registers are plain flops, so a write is always taken at once.
    assign o_cfg_ready = 1'b1;

    // The controller only sequences; all arithmetic and storage live in the
    // datapath, which reports progress back through the status struct.
    dhd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_op    (op),
        .i_stat  (stat)
    );

    dhd_dpath #(
        .MAX_BOXES   (MAX_BOXES),
        .CLASSES_MAX (CLASSES_MAX)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_op        (op),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire

// ===== test/detection_head_decode_tb.sv =====
// ============================================================================
// detection_head_decode_tb: self-checking bench for the detection head decoder
// Streams Q8.8 logits through the decoder under several register settings and
// random handshake gaps. An internal fixed-point predictor builds the expected
// results, which a monitor compares field by field.
// ============================================================================
`default_nettype none

module detection_head_decode_tb;

    timeunit 1ns;
    timeprecision 1ps;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_ready;
    dhd_pkg::t_in   i_data;
    logic           o_valid;
    logic           i_ready;
    dhd_pkg::t_out  o_data;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [63:0]    i_cfg_data;

    detection_head_decode DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Predictor copy of the registers and the decoder state.
    logic [2:0]  boxes_reg;
    logic [6:0]  classes_reg;
    logic        mode_reg;
    logic [63:0] anch_lo_reg;
    logic [63:0] anch_hi_reg;
    logic [1:0]  box_cnt;
    logic [6:0]  chan_cnt;
    int          class_logits [64];
    int          run_peak;

    dhd_pkg::t_in  pending_items [$];
    dhd_pkg::t_out expected_results [$];
    int            mismatches;

    // e^-a in Q1.30 for unsigned Q8.8 a, same polynomial as the hardware.
    function automatic logic [31:0] neg_exp(input logic [31:0] a);
        logic [63:0] y, n, f, m;
        y = 64'(a) * 64'd94548;
        n = y >> 24;
        f = (y >> 8) & 64'hFFFF;
        m = 64'd65536 - ((f * 64'd44014) >> 16) + ((((f * f) >> 16) * 64'd11246) >> 16);
        if (n >= 31)
            return 32'd0;
        return 32'((m << 14) >> n);
    endfunction

    function automatic logic [31:0] sigmoid_q16(input int x);
        logic [63:0] d, s;
        logic [31:0] mag;
        mag = (x < 0) ? 32'(-x) : 32'(x);
        d = (64'd1 << 30) + 64'(neg_exp(mag));
        s = ((64'd1 << 46) + d / 2) / d;
        return (x < 0) ? 32'(64'd65536 - s) : 32'(s);
    endfunction

    function automatic logic [31:0] box_size(input int x, input logic [1:0] box,
                                             input logic which);
        logic [63:0] word, e, r;
        logic [15:0] anchor;
        int v;
        word = box[1] ? anch_hi_reg : anch_lo_reg;
        anchor = 16'(word >> (box[0] * 32 + which * 16));
        v = (x < -1024) ? -1024 : ((x > 1024) ? 1024 : x);
        e = (64'(neg_exp(32'(1024 - v))) * 64'd3578144) >> 30;
        r = (e * 64'(anchor)) >> 8;
        return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(r);
    endfunction

    task automatic push_result(input logic [31:0] v, input logic [1:0] b,
                               input logic [6:0] c, input logic last);
        dhd_pkg::t_out r;
        r.activated = v;
        r.box_index = b;
        r.channel_index = c;
        r.run_last = last;
        expected_results.push_back(r);
    endtask

    // Advance the predictor by one accepted item and queue its results.
    task automatic decode_item(input dhd_pkg::t_in it);
        int x, nb, nc, k, diff;
        logic [31:0] e [64];
        logic [31:0] sum, esum, p;
        logic [1:0] b;
        logic [6:0] ch;
        x = it.logit;
        nb = (boxes_reg < 1) ? 1 : ((boxes_reg > 4) ? 4 : boxes_reg);
        nc = (classes_reg < 1) ? 1 : ((classes_reg > 64) ? 64 : classes_reg);
        if (it.cell_start) begin
            box_cnt = 0;
            chan_cnt = 0;
        end
        b = box_cnt;
        ch = chan_cnt;
        if (ch < dhd_pkg::NUM_GEOM) begin
            if (ch == 2 || ch == 3)
                push_result(box_size(x, b, ch == 3), b, ch, 1'b1);
            else
                push_result(sigmoid_q16(x), b, ch, 1'b1);
        end else begin
            k = ch - dhd_pkg::NUM_GEOM;
            if (k >= 64)
                k = 63;
            if (mode_reg) begin
                push_result(sigmoid_q16(x), b, ch, 1'b1);
            end else begin
                class_logits[k] = x;
                if (k == 0 || x > run_peak)
                    run_peak = x;
                if (k + 1 >= nc) begin
                    sum = 0;
                    for (int c = 0; c <= k; c++) begin
                        diff = run_peak - class_logits[c];
                        if (diff < 0)
                            diff = 0;
                        e[c] = neg_exp(32'(diff)) >> 14;
                        sum += e[c];
                    end
                    esum = sum & 32'h7F_FFFF;
                    for (int c = 0; c <= k; c++) begin
                        p = 0;
                        if (esum != 0)
                            p = 32'(((64'(e[c]) << 16) + esum / 2) / esum);
                        push_result(p, b, 7'(dhd_pkg::NUM_GEOM + c), c == k);
                    end
                end
            end
        end
        ch++;
        if (ch >= dhd_pkg::NUM_GEOM + nc) begin
            ch = 0;
            b++;
            if (b >= nb)
                b = 0;
        end
        chan_cnt = ch;
        box_cnt = b;
    endtask

    // Random gap: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Set after each rising edge that accepted an input item.
    logic in_fire;
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_valid && o_ready;
    end

    // Driver: presents queued items, holding each until it is accepted.
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else if (i_valid && !in_fire) begin
            // The item is still waiting for acceptance.
        end else if (send_gap > 0) begin
            send_gap--;
            i_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            i_data <= pending_items.pop_front();
            i_valid <= 1'b1;
            send_gap = gap_len();
        end else begin
            i_valid <= 1'b0;
        end
    end

    // The receiver stalls at random.
    int stall_len;
    always @(negedge i_clk) begin
        if (stall_len > 0) begin
            stall_len--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                stall_len = gap_len();
        end
    end

    // Monitor: predicts on each accepted item and checks each result.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready)
            decode_item(i_data);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_data);
            end else begin
                dhd_pkg::t_out want;
                want = expected_results.pop_front();
                if (want.activated !== o_data.activated || want.box_index !== o_data.box_index
                    || want.channel_index !== o_data.channel_index
                    || want.run_last !== o_data.run_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, o_data);
                end
            end
        end
    end

    // Writes one register while the block is idle, mirroring it in the predictor.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            dhd_pkg::CFG_BOXES:   boxes_reg = val[2:0];
            dhd_pkg::CFG_CLASSES: classes_reg = val[6:0];
            dhd_pkg::CFG_MODE:    mode_reg = val[0];
            dhd_pkg::CFG_ANCH_LO: anch_lo_reg = val;
            dhd_pkg::CFG_ANCH_HI: anch_hi_reg = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every item is sent and every result is back, then lets a
    // softmax pass that has no result yet run out.
    task automatic drain();
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_logit();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'($urandom_range(0, 2048)) - 16'sd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queues whole cells under the current register setting.
    task automatic queue_cells(input int ncells);
        dhd_pkg::t_in it;
        int nb, nc;
        nb = (boxes_reg < 1) ? 1 : ((boxes_reg > 4) ? 4 : boxes_reg);
        nc = (classes_reg < 1) ? 1 : ((classes_reg > 64) ? 64 : classes_reg);
        for (int c = 0; c < ncells; c++)
            for (int i = 0; i < nb * (dhd_pkg::NUM_GEOM + nc); i++) begin
                it.logit = rand_logit();
                it.cell_start = (i == 0);
                pending_items.push_back(it);
            end
    endtask

    // Noise: a cell start partway into a run, dropping buffered logits.
    task automatic queue_broken(input int n);
        dhd_pkg::t_in it;
        for (int i = 0; i < n; i++) begin
            it.logit = rand_logit();
            it.cell_start = (i == 0);
            pending_items.push_back(it);
        end
    endtask

    initial begin
        dhd_pkg::t_in it;
        mismatches = 0;
        stall_len = 0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = dhd_pkg::CFG_BOXES;
        i_cfg_data = '0;
        boxes_reg = 3;
        classes_reg = 20;
        mode_reg = 0;
        anch_lo_reg = '0;
        anch_hi_reg = '0;
        box_cnt = 0;
        chan_cnt = 0;
        run_peak = -32768;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: one box, three classes, softmax, extreme logits and anchors.
        write_reg(dhd_pkg::CFG_BOXES, 64'd1);
        write_reg(dhd_pkg::CFG_CLASSES, 64'd3);
        write_reg(dhd_pkg::CFG_ANCH_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(dhd_pkg::CFG_ANCH_HI, 64'h0100_0200_0080_FFFF);
        begin
            logic signed [15:0] dv [8];
            dv = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000,
                   16'sh7FFF, 16'sh8000, 16'sh0400};
            for (int i = 0; i < 8; i++) begin
                it.logit = dv[i];
                it.cell_start = (i == 0);
                pending_items.push_back(it);
            end
        end
        // A cell start inside the class run drops the buffered logits.
        queue_broken(7);
        queue_cells(1);
        drain();

        // Out-of-range register values saturate; sigmoid classes.
        write_reg(dhd_pkg::CFG_BOXES, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(dhd_pkg::CFG_CLASSES, 64'd0);
        write_reg(dhd_pkg::CFG_MODE, 64'd1);
        queue_cells(2);
        drain();

        // Classes shrunk in the middle of a softmax run end it early.
        write_reg(dhd_pkg::CFG_MODE, 64'd0);
        write_reg(dhd_pkg::CFG_BOXES, 64'd2);
        write_reg(dhd_pkg::CFG_CLASSES, 64'd10);
        queue_broken(12);
        drain();
        write_reg(dhd_pkg::CFG_CLASSES, 64'd4);
        for (int i = 0; i < 3; i++) begin
            it.logit = rand_logit();
            it.cell_start = 0;
            pending_items.push_back(it);
        end
        drain();

        // Random phases under varied settings; the drain between phases also
        // holds the sender until every expected result has arrived.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(dhd_pkg::CFG_BOXES, (ph == 3 || ph == 5) ? 64'd1 :
                      64'($urandom_range(1, 4)));
            write_reg(dhd_pkg::CFG_CLASSES, (ph == 3) ? 64'd64 : (ph == 5) ? 64'd127 :
                      64'($urandom_range(1, 8)));
            write_reg(dhd_pkg::CFG_MODE, 64'($urandom_range(0, 1)));
            write_reg(dhd_pkg::CFG_ANCH_LO, {$urandom, $urandom});
            write_reg(dhd_pkg::CFG_ANCH_HI, {$urandom, $urandom});
            if (ph == 3 || ph == 5) begin
                queue_cells(1);
            end else begin
                while (pending_items.size() < 10) begin
                    if ($urandom_range(0, 5) == 0)
                        queue_broken($urandom_range(1, 15));
                    else
                        queue_cells(1);
                end
            end
            drain();
        end
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #8ms;
        $display("tb: failure");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
design/dhd_pkg.sv
design/dhd_ctrl.sv
design/dhd_dpath.sv
design/detection_head_decode.sv
test/detection_head_decode_tb.sv
